// ===== rtl/core/slmrs_pkg.sv =====
package slmrs_pkg;

  // Default number of 16x16 glyphs the store can hold.
  localparam int GLYPH_CAPACITY_DEF = 64;

  localparam int GLYPH_BYTES       = 32;
  localparam int BLANK_LEAD_GLYPHS = 4;
  localparam int FETCH_BYTES       = 10;
  localparam int OUT_BYTES         = 8;
  localparam int ROW_W             = 4;
  localparam int SCROLL_BIT_W      = 4;
  localparam int GLYPH_POS_W       = 7;
  localparam int GLYPH_COUNT_W     = 7;
  localparam int DIVIDER_W         = 8;
  localparam int LOAD_ADDR_W       = 11;
  localparam int CFG_DATA_W        = 8;
  localparam int CFG_INDEX_W       = 1;
  // Glyph index plus byte offset, wide enough for the largest capacity.
  localparam int FULL_ADDR_W       = GLYPH_POS_W + 5;

  localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 8'd40;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_e;

  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_DIVIDER = 1'b1;

  typedef struct packed {
    logic [SCROLL_BIT_W-1:0] scroll_bit;
    logic [GLYPH_POS_W-1:0]  glyph_pos;
    logic [ROW_W-1:0]        row;
  } scan_pos_t;

  typedef struct packed {
    logic tick;
    logic row_step;
  } scan_ctl_t;

endpackage

// ===== rtl/core/slmrs_in_if.sv =====
interface slmrs_in_if import slmrs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [LOAD_ADDR_W-1:0] load_address;
  logic [7:0]             load_data;

  modport source (output valid, output op, output load_address, output load_data,
                  input ready);
  modport sink   (input valid, input op, input load_address, input load_data,
                  output ready);
endinterface

// ===== rtl/core/slmrs_out_if.sv =====
interface slmrs_out_if import slmrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row_select;
  logic [8*OUT_BYTES-1:0]   row_pixels;

  modport source (output valid, output row_select, output row_pixels, input ready);
  modport sink   (input valid, input row_select, input row_pixels, output ready);
endinterface

// ===== rtl/core/scrolling_led_matrix_row_scan.sv =====
// Load beats return nothing and leave the block ready for the next beat.
// A scan beat passes from acceptance through the states tick (step the scroll
// counters), fetch (ten reads through the single store port), drain (the last
// read lands) and emit (compose the row) before its row is offered on the output;
// emit waits while the output register is full and not taken. No new beat is taken meanwhile.
// Reset clears the counters and registers; the glyph store is not cleared.
module scrolling_led_matrix_row_scan import slmrs_pkg::*; #(
  parameter int GlyphCapacity = GLYPH_CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  slmrs_in_if.sink               in_ch,
  slmrs_out_if.source            out_ch
);

  localparam int StoreBytes = GlyphCapacity * GLYPH_BYTES;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int StepW      = $clog2(FETCH_BYTES);
  localparam logic [StepW-1:0] LastStep = StepW'(FETCH_BYTES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Configuration registers. They must only be written while no beat is in flight; the block does not enforce it.
  logic [GLYPH_COUNT_W-1:0] glyph_count_q;
  logic [DIVIDER_W-1:0]     divider_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_count_q <= '0;
      divider_q     <= DIVIDER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GLYPH_COUNT:    glyph_count_q <= cfg_data_i[GLYPH_COUNT_W-1:0];
        CFG_SCROLL_DIVIDER: divider_q     <= cfg_data_i[DIVIDER_W-1:0];
        default:            ;
      endcase
    end
  end

  state_e               state_q;
  logic [StepW-1:0]     step_q;
  logic                 rd_valid_q;
  logic                 rd_blank_q;
  logic [7:0]           buf_q [FETCH_BYTES];
  logic                 out_valid_q;
  logic [ROW_W-1:0]     out_row_q;
  logic [8*OUT_BYTES-1:0] out_pixels_q;

  scan_pos_t            pos;
  scan_ctl_t            ctl;

  logic                 in_accept;
  logic                 load_hit;
  logic                 out_free;

  // The scan counters live in their own unit; the sequencer pulses it once per scan
  // beat to advance the tick and once more when the row is written to the output register.
  slmrs_scroll_state u_scroll (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .glyph_count_i (glyph_count_q),
    .divider_i     (divider_q),
    .pos_o         (pos)
  );

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;

  always_comb begin
    ctl.tick     = (state_q == ST_TICK);
    ctl.row_step = (state_q == ST_EMIT) && out_free;
  end

  // Fetch address generation. Step s reads glyph column s/2 of the five in view,
  // left half on even steps and right half on odd ones. The first four glyph
  // positions are blank lead-in, as is anything past the loaded count or the store.
  logic [GLYPH_POS_W:0]     glyph_sum;
  logic [GLYPH_POS_W:0]     glyph_end;
  logic [GLYPH_POS_W:0]     store_glyph;
  logic                     fetch_blank;
  logic [FULL_ADDR_W-1:0]   fetch_addr;
  logic [FULL_ADDR_W-1:0]   load_addr;
  logic [AddrW-1:0]         mem_addr;
  logic                     mem_we;
  logic                     mem_re;
  logic [7:0]               mem_rdata;

  always_comb begin
    glyph_sum   = {1'b0, pos.glyph_pos} + (GLYPH_POS_W+1)'(step_q[StepW-1:1]);
    glyph_end   = {1'b0, glyph_count_q} + (GLYPH_POS_W+1)'(BLANK_LEAD_GLYPHS);
    store_glyph = glyph_sum - (GLYPH_POS_W+1)'(BLANK_LEAD_GLYPHS);
    fetch_blank = (glyph_sum < (GLYPH_POS_W+1)'(BLANK_LEAD_GLYPHS)) ||
                  (glyph_sum >= glyph_end) ||
                  ({1'b0, store_glyph} >= (GLYPH_POS_W+2)'(GlyphCapacity));
    fetch_addr  = {store_glyph[GLYPH_POS_W-1:0], step_q[0], pos.row};
    load_addr   = FULL_ADDR_W'(in_ch.load_address);
    // Loads beyond the store are dropped.
    load_hit    = ({1'b0, load_addr} < (FULL_ADDR_W+1)'(StoreBytes));
    mem_we      = in_accept && (in_ch.op == OP_LOAD) && load_hit;
    mem_re      = (state_q == ST_FETCH);
    mem_addr    = mem_re ? fetch_addr[AddrW-1:0] : load_addr[AddrW-1:0];
  end

  slmrs_glyph_store #(
    .GlyphCapacity (GlyphCapacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (in_ch.load_data),
    .rdata_o (mem_rdata)
  );

  // Row composition. Scroll bits eight and up skip one byte; the low three bits
  // shift each 16-bit pair of neighbors. The panel is driven active low.
  logic [SCROLL_BIT_W-2:0] shift;
  logic                    skip;
  logic [15:0]             pair;
  logic [15:0]             shifted;
  logic [8*OUT_BYTES-1:0]  pixels;

  always_comb begin
    skip   = pos.scroll_bit[SCROLL_BIT_W-1];
    shift  = pos.scroll_bit[SCROLL_BIT_W-2:0];
    pixels = '0;
    pair    = '0;
    shifted = '0;
    for (int k = 0; k < OUT_BYTES; k++) begin
      pair    = skip ? {buf_q[k+2], buf_q[k+1]} : {buf_q[k+1], buf_q[k]};
      shifted = pair >> shift;
      pixels[8*k +: 8] = ~shifted[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      rd_valid_q   <= 1'b0;
      rd_blank_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_row_q    <= '0;
      out_pixels_q <= '0;
      for (int i = 0; i < FETCH_BYTES; i++) begin
        buf_q[i] <= '0;
      end
    end else begin
      // The output register holds its row until the receiver takes it, and is
      // refilled in the same cycle that it is freed.
      out_valid_q <= ((state_q == ST_EMIT) && out_free) || (out_valid_q && !out_ch.ready);

      // Read data lands in the cycle after its address; it shifts in from the top,
      // so after ten reads the first byte sits at the bottom.
      rd_valid_q <= mem_re;
      rd_blank_q <= fetch_blank;
      if (rd_valid_q) begin
        for (int i = 0; i < FETCH_BYTES - 1; i++) begin
          buf_q[i] <= buf_q[i+1];
        end
        buf_q[FETCH_BYTES-1] <= rd_blank_q ? 8'h00 : mem_rdata;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && (in_ch.op == OP_SCAN)) begin
            state_q <= ST_TICK;
          end
        end
        ST_TICK: begin
          step_q  <= '0;
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_row_q    <= ~pos.row;
            out_pixels_q <= pixels;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.row_select = out_row_q;
  assign out_ch.row_pixels = out_pixels_q;

endmodule

// ===== rtl/core/slmrs_glyph_store.sv =====
module slmrs_glyph_store import slmrs_pkg::*; #(
  parameter int GlyphCapacity = GLYPH_CAPACITY_DEF,
  localparam int Depth        = GlyphCapacity * GLYPH_BYTES,
  localparam int AddrW        = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  // Single-port byte store; a write wins the port over a read.
  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/slmrs_scroll_state.sv =====
module slmrs_scroll_state import slmrs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scan_ctl_t                ctl_i,
  input  logic [GLYPH_COUNT_W-1:0] glyph_count_i,
  input  logic [DIVIDER_W-1:0]     divider_i,
  output scan_pos_t                pos_o
);

  logic [DIVIDER_W-1:0]     tick_q, tick_d;
  logic [DIVIDER_W-1:0]     tick_inc;
  logic [SCROLL_BIT_W-1:0]  scroll_inc;
  logic [GLYPH_POS_W:0]     glyph_inc;
  logic [GLYPH_POS_W:0]     glyph_end;
  scan_pos_t                pos_q, pos_d;

  always_comb begin
    tick_inc   = tick_q + 1'b1;
    scroll_inc = pos_q.scroll_bit + 1'b1;
    glyph_inc  = {1'b0, pos_q.glyph_pos} + 1'b1;
    glyph_end  = {1'b0, glyph_count_i} + (GLYPH_POS_W+1)'(BLANK_LEAD_GLYPHS);
    tick_d     = tick_q;
    pos_d      = pos_q;
    if (ctl_i.tick) begin
      tick_d = tick_inc;
      // A zero divider only matches after the tick counter wraps.
      if (tick_inc == divider_i) begin
        tick_d           = '0;
        pos_d.scroll_bit = scroll_inc;
        if (scroll_inc == '0) begin
          pos_d.glyph_pos = (glyph_inc >= glyph_end) ? '0 : glyph_inc[GLYPH_POS_W-1:0];
        end
      end
    end
    if (ctl_i.row_step) begin
      pos_d.row = pos_q.row + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      pos_q  <= '0;
    end else begin
      tick_q <= tick_d;
      pos_q  <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== tb/sv/slmrs_row_checker.sv =====
`timescale 1ns / 1ps

module slmrs_row_checker import slmrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  slmrs_in_if                    in_ch,
  slmrs_out_if                   out_ch,
  output int                     mismatches_o,
  output int                     rows_pending_o
);

  localparam int StoreBytes = GLYPH_CAPACITY_DEF * GLYPH_BYTES;
  localparam int BlankBytes = BLANK_LEAD_GLYPHS * GLYPH_BYTES;
  localparam int HalfGlyph  = GLYPH_BYTES / 2;
  localparam int MaxPrinted = 100;

  typedef struct packed {
    logic [ROW_W-1:0]       row_select;
    logic [8*OUT_BYTES-1:0] row_pixels;
  } panel_row_t;

  logic [7:0]               glyph_mem [StoreBytes];
  logic [GLYPH_COUNT_W-1:0] glyph_count;
  logic [DIVIDER_W-1:0]     divider;
  logic [DIVIDER_W-1:0]     tick_cnt;
  logic [SCROLL_BIT_W-1:0]  scroll_pos;
  logic [GLYPH_POS_W-1:0]   glyph_pos;
  logic [ROW_W-1:0]         row_cnt;
  panel_row_t               expected_rows [$];
  panel_row_t               oldest_row;
  int                       fail_tally = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_tally++;
    if (fail_tally <= MaxPrinted) begin
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // Byte of the virtual glyph strip; the lead-in glyphs and anything past the
  // loaded glyphs are blank.
  function automatic logic [7:0] strip_byte(int unsigned linear);
    int unsigned bound;
    bound = int'(glyph_count) * GLYPH_BYTES + BlankBytes;
    if (linear < BlankBytes || linear >= bound) return 8'h00;
    if (linear - BlankBytes >= StoreBytes) return 8'h00;
    return glyph_mem[linear - BlankBytes];
  endfunction

  task automatic predict_row();
    logic [7:0]  fetched [FETCH_BYTES];
    logic [15:0] pair;
    int unsigned next_pos;
    int unsigned left_base;
    int          skip;
    int          shift_amt;
    panel_row_t  row;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt == divider) begin
      tick_cnt   = '0;
      scroll_pos = scroll_pos + 1'b1;
      if (scroll_pos == '0) begin
        next_pos = int'(glyph_pos) + 1;
        if (next_pos >= int'(glyph_count) + BLANK_LEAD_GLYPHS) next_pos = 0;
        glyph_pos = next_pos[GLYPH_POS_W-1:0];
      end
    end
    left_base = int'(glyph_pos) * GLYPH_BYTES;
    for (int j = 0; j < FETCH_BYTES / 2; j++) begin
      fetched[2*j]   = strip_byte(left_base + j * GLYPH_BYTES + row_cnt);
      fetched[2*j+1] = strip_byte(left_base + HalfGlyph + j * GLYPH_BYTES + row_cnt);
    end
    // The upper scroll bit skips a whole byte; the lower three shift within a pair.
    skip      = scroll_pos[SCROLL_BIT_W-1];
    shift_amt = scroll_pos[2:0];
    for (int k = 0; k < OUT_BYTES; k++) begin
      pair = {fetched[k + skip + 1], fetched[k + skip]};
      row.row_pixels[8*k +: 8] = ~pair[shift_amt +: 8];
    end
    row.row_select = '1 - row_cnt;
    row_cnt        = row_cnt + 1'b1;
    expected_rows.push_back(row);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_count = '0;
      divider     = DIVIDER_RESET;
      tick_cnt    = '0;
      scroll_pos  = '0;
      glyph_pos   = '0;
      row_cnt     = '0;
      expected_rows.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GLYPH_COUNT) begin
          glyph_count = cfg_data_i[GLYPH_COUNT_W-1:0];
        end else if (cfg_index_i == CFG_SCROLL_DIVIDER) begin
          divider = cfg_data_i[DIVIDER_W-1:0];
        end
      end
      // Outgoing beat first, so a row can never match the scan accepted at this edge.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("row beat with no row expected", out_ch.row_pixels, '0);
        end else begin
          oldest_row = expected_rows.pop_front();
          if (out_ch.row_select !== oldest_row.row_select) begin
            report_mismatch("row_select", out_ch.row_select, oldest_row.row_select);
          end
          if (out_ch.row_pixels !== oldest_row.row_pixels) begin
            report_mismatch("row_pixels", out_ch.row_pixels, oldest_row.row_pixels);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_SCAN) begin
          predict_row();
        end else if (in_ch.load_address < StoreBytes) begin
          glyph_mem[in_ch.load_address] = in_ch.load_data;
        end
      end
    end
    rows_pending_o <= expected_rows.size();
    mismatches_o   <= fail_tally;
  end

endmodule

// ===== tb/sv/scrolling_led_matrix_row_scan_test.sv =====
`timescale 1ns / 1ps

module scrolling_led_matrix_row_scan_test;
  import slmrs_pkg::*;

  localparam int StoreBytes = GLYPH_CAPACITY_DEF * GLYPH_BYTES;
  // Largest glyph count that any phase sets; the fill covers exactly these glyphs.
  localparam int FillGlyphs = 12;
  localparam int FillBytes  = FillGlyphs * GLYPH_BYTES;
  // Margin that lets the block settle in idle before the next register write.
  localparam int DrainCycles = 16;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  bit                     idle_en;
  int                     stall_left = 0;
  int                     mismatches;
  int                     rows_pending;

  slmrs_in_if  glyph_in_ch ();
  slmrs_out_if row_out_ch ();

  scrolling_led_matrix_row_scan dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_ch       (glyph_in_ch),
    .out_ch      (row_out_ch)
  );

  // The checker sees the same channels and register writes as the block does,
  // keeps its own copy of the glyph store and scan counters, and compares every
  // row beat with the oldest predicted row.
  slmrs_row_checker row_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_ch          (glyph_in_ch),
    .out_ch         (row_out_ch),
    .mismatches_o   (mismatches),
    .rows_pending_o (rows_pending)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The row receiver stalls in random bursts while idling is on.
  // Bursts start at random, so they can land on any cycle of a scan, including
  // the cycle that a finished row is first offered.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left       <= 0;
      row_out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      row_out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      row_out_ch.ready <= 1'b0;
    end else begin
      row_out_ch.ready <= 1'b1;
    end
  end

  // Offers one input beat and returns once it is taken. While idling is on, a random
  // gap may come first. Valid stays high from one beat to the next when there is no gap.
  task automatic send_beat(op_e op, logic [LOAD_ADDR_W-1:0] addr, logic [7:0] data);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      glyph_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    glyph_in_ch.valid        <= 1'b1;
    glyph_in_ch.op           <= op;
    glyph_in_ch.load_address <= addr;
    glyph_in_ch.load_data    <= data;
    do @(posedge clk_i); while (!glyph_in_ch.ready);
  endtask

  // Drops valid and waits until every predicted row has come out. The first
  // edge lets the pending count take in a scan accepted at the last edge.
  task automatic quiesce();
    glyph_in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes both registers on back-to-back edges; the block must be idle.
  task automatic set_scan_config(int glyphs, int divider);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GLYPH_COUNT;
    cfg_data  <= CFG_DATA_W'(glyphs);
    @(posedge clk_i);
    cfg_index <= CFG_SCROLL_DIVIDER;
    cfg_data  <= CFG_DATA_W'(divider);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One random phase under a fixed setting. Most beats are scans; the loads go
  // half to the loaded glyphs and the glyph after them, and half anywhere in the store.
  // Scan beats carry random address and data, which the block must ignore.
  task automatic run_phase(int glyphs, int divider, int beats, bit idle);
    int span;
    idle_en <= idle;
    set_scan_config(glyphs, divider);
    span = (glyphs + 1) * GLYPH_BYTES;
    if (span > StoreBytes) span = StoreBytes;
    repeat (beats) begin
      if ($urandom_range(0, 99) < 85) begin
        send_beat(OP_SCAN, LOAD_ADDR_W'($urandom), 8'($urandom));
      end else if ($urandom_range(0, 1) == 0) begin
        send_beat(OP_LOAD, LOAD_ADDR_W'($urandom_range(0, span - 1)), 8'($urandom));
      end else begin
        send_beat(OP_LOAD, LOAD_ADDR_W'($urandom_range(0, StoreBytes - 1)), 8'($urandom));
      end
    end
    quiesce();
  endtask

  initial begin
    // Every input is known from time zero.
    rst_ni                   <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= CFG_GLYPH_COUNT;
    cfg_data                 <= '0;
    idle_en                  <= 1'b0;
    glyph_in_ch.valid        <= 1'b0;
    glyph_in_ch.op           <= OP_LOAD;
    glyph_in_ch.load_address <= '0;
    glyph_in_ch.load_data    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Right after reset no glyph is loaded, so every fetch
    // falls in the blank lead-in or past the loaded range and its read data
    // is replaced by zero: these rows must be all ones, with the row select
    // counting down from 15.
    idle_en <= 1'b1;
    repeat (4) send_beat(OP_SCAN, '0, '0);
    quiesce();

    // Fill every glyph up to the largest glyph count that a phase sets, so
    // that no later fetch can touch an entry that was never written.
    idle_en <= 1'b0;
    for (int a = 0; a < FillBytes; a++) begin
      send_beat(OP_LOAD, LOAD_ADDR_W'(a), 8'($urandom));
    end
    quiesce();

    // One glyph loaded and the divider set to one. The tick counter still holds
    // the earlier scans' count and only meets the divider after it wraps, so these
    // scans leave the scroll offset and glyph position at zero, and the window shows
    // the four lead-in glyphs and the loaded one. The loads hit both ends of the
    // address range and the data extremes.
    idle_en <= 1'b1;
    set_scan_config(1, 1);
    send_beat(OP_LOAD, '0, 8'hFF);
    send_beat(OP_LOAD, LOAD_ADDR_W'(StoreBytes - 1), 8'h00);
    send_beat(OP_LOAD, LOAD_ADDR_W'(16), 8'h01);
    send_beat(OP_LOAD, LOAD_ADDR_W'(17), 8'h80);
    send_beat(OP_LOAD, LOAD_ADDR_W'(31), 8'hA5);
    repeat (18) send_beat(OP_SCAN, '1, '1);
    quiesce();

    // Random phases. Small glyph counts run with fast dividers; the tick counter
    // carries over from phase to phase. The largest filled glyph count, the largest
    // nonzero divider and a zero divider (one step per 256 ticks) each get a phase.
    // The last phase runs with no idling on either side.
    run_phase(3, 1, 90, 1'b1);
    run_phase(FillGlyphs, 1, 110, 1'b1);
    run_phase(0, 255, 30, 1'b1);
    run_phase(1, 2, 70, 1'b1);
    run_phase(2, 0, 320, 1'b1);
    run_phase(5, 3, 120, 1'b0);

    if (mismatches == 0 && rows_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Slowest correct run: about 1150 beats, each a scan behind the longest input
  // gap, with its work and the longest output stall, near 0.5 ms. The limit allows
  // many times that.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== scrolling_led_matrix_row_scan.f =====
rtl/core/slmrs_pkg.sv
rtl/core/slmrs_in_if.sv
rtl/core/slmrs_out_if.sv
rtl/core/slmrs_glyph_store.sv
rtl/core/slmrs_scroll_state.sv
rtl/core/scrolling_led_matrix_row_scan.sv
tb/sv/slmrs_row_checker.sv
tb/sv/scrolling_led_matrix_row_scan_test.sv
